@@ rtl/core/fsc_pkg.sv @@
// ----------------------------------------------------------------------------
// fsc_pkg - shared types and constants of the servo speed controller
// Event codes, job format between front and back, divider and queue status.
// ----------------------------------------------------------------------------
`default_nettype none

package fsc_pkg;

    // event codes on the input channel
    localparam logic [1:0] CMD_BUTTON  = 2'd0;
    localparam logic [1:0] CMD_POT     = 2'd1;
    localparam logic [1:0] CMD_EDGE    = 2'd2;
    localparam logic [1:0] CMD_REFRESH = 2'd3;

    // configuration register indexes
    localparam logic CFG_MIN_FEEDBACK = 1'b0;
    localparam logic CFG_MAX_FEEDBACK = 1'b1;

    localparam logic [11:0] MIN_FEEDBACK_RST = 12'd32;
    localparam logic [11:0] MAX_FEEDBACK_RST = 12'd1076;

    // direction codes on the result channel
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_CW   = 2'd1;
    localparam logic [1:0] DIR_CCW  = 2'd2;

    // drive pulse
    localparam logic [10:0] PULSE_STOP     = 11'd1500;
    localparam logic [10:0] PULSE_CW_BASE  = 11'd1480;
    localparam logic [10:0] PULSE_CCW_BASE = 11'd1520;
    localparam logic [10:0] PULSE_MIN      = 11'd1280;
    localparam logic [10:0] PULSE_MAX      = 11'd1720;
    localparam logic [7:0]  POT_GAIN       = 8'd200;
    localparam logic [12:0] POT_FULL_SCALE = 13'd4095;

    // angle and speed scaling
    localparam logic [8:0]  ANGLE_FULL  = 9'd360;
    localparam logic [31:0] SPEED_SCALE = 32'd5000000;

    localparam logic signed [15:0] RPM_POS_SAT = 16'sh7FFF;
    localparam logic signed [15:0] RPM_NEG_SAT = 16'sh8000;

    // shared restoring divider
    localparam int DIV_NUM_W   = 31;
    localparam int DIV_DEN_W   = 34;
    localparam int DIV_CNT_W   = 5;
    localparam int ANGLE_NUM_W = 21;
    localparam int ANGLE_PAD   = DIV_NUM_W - ANGLE_NUM_W;
    localparam logic [DIV_CNT_W-1:0] ANGLE_STEPS = DIV_CNT_W'(ANGLE_NUM_W);
    localparam logic [DIV_CNT_W-1:0] SPEED_STEPS = DIV_CNT_W'(DIV_NUM_W);

    // job queue
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_BUTTON,
        OP_POT,
        OP_RISE,
        OP_FALL,
        OP_REFRESH
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [7:0]  pot_speed;   // pot*200/4095, precomputed for pot beats
        logic [31:0] ts;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
        logic [DIV_CNT_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } t_div_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ANGLE,
        S_ANGLE_DIV,
        S_SPEED_MUL,
        S_SPEED_START,
        S_SPEED_DIV,
        S_DONE
    } t_back_state;

endpackage

`default_nettype wire

@@ rtl/core/feedback_servo_speed_controller.sv @@
// ----------------------------------------------------------------------------
// feedback_servo_speed_controller - continuous-rotation servo controller
// Mode and drive pulse from button and pot events, shaft angle and speed
// from the feedback line.
// ----------------------------------------------------------------------------
// Every accepted input beat yields exactly one result beat showing the state
// after that event. Intake and execution are split by a two-entry job queue,
// so the input side keeps taking beats while the back end computes or while
// a result waits on a stalled output. Button, pot, rising-edge and refresh
// beats go from the queue head through S_IDLE and S_DONE to the result
// register. A falling edge whose high time lies inside the calibrated span
// runs a 21-step angle divide then a 31-step speed divide, both on one shared
// one-bit-per-cycle divider; a clamped angle skips the first divide and the
// first edge (or a zero time gap) skips the second. The divider sets the
// sustained rate for feedback events. The user must write min/max feedback
// registers only while no beat is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module feedback_servo_speed_controller (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration write port
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_index,
    input  wire logic [11:0]        i_cfg_data,
    // event beats in
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_cmd,
    input  wire logic [11:0]        i_pot_sample,
    input  wire logic               i_edge_level,
    input  wire logic [31:0]        i_timestamp_us,
    // result beats out
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [10:0]             o_pulse_width_us,
    output logic [1:0]              o_direction,
    output logic [8:0]              o_angle_deg,
    output logic signed [15:0]      o_rpm_tenths
);

    fsc_pkg::t_job      w_push_job;
    fsc_pkg::t_job      w_head_job;
    fsc_pkg::t_q_stat   w_q_stat;
    fsc_pkg::t_div_req  w_div_req;
    fsc_pkg::t_div_rsp  w_div_rsp;
    logic               w_push;
    logic               w_pop;

    // intake: decode the event and precompute the pot speed term
    fsc_front u_front (
        .i_valid        (i_valid),
        .i_cmd          (i_cmd),
        .i_pot_sample   (i_pot_sample),
        .i_edge_level   (i_edge_level),
        .i_timestamp_us (i_timestamp_us),
        .i_q_stat       (w_q_stat),
        .o_stall        (o_stall),
        .o_push         (w_push),
        .o_job          (w_push_job)
    );

    // decoupling queue
    fsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_stat  (w_q_stat)
    );

    // shared divider for angle and speed
    fsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // execution and result register
    fsc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_job            (w_head_job),
        .i_q_stat         (w_q_stat),
        .o_pop            (w_pop),
        .o_div_req        (w_div_req),
        .i_div_rsp        (w_div_rsp),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_pulse_width_us (o_pulse_width_us),
        .o_direction      (o_direction),
        .o_angle_deg      (o_angle_deg),
        .o_rpm_tenths     (o_rpm_tenths)
    );

endmodule

`default_nettype wire

@@ rtl/core/fsc_front.sv @@
// ----------------------------------------------------------------------------
// fsc_front - event intake and classification
// Decodes each input beat into a job and pushes it into the job queue.
// ----------------------------------------------------------------------------
`default_nettype none

module fsc_front (
    input  wire logic           i_valid,
    input  wire logic [1:0]     i_cmd,
    input  wire logic [11:0]    i_pot_sample,
    input  wire logic           i_edge_level,
    input  wire logic [31:0]    i_timestamp_us,
    input  wire fsc_pkg::t_q_stat i_q_stat,
    output logic                o_stall,
    output logic                o_push,
    output fsc_pkg::t_job       o_job
);

    logic [19:0] w_pot_prod;
    logic [7:0]  w_q0;
    logic [12:0] w_rem;

    // x/4095 = (x>>12) plus one when (x & 4095) + (x>>12) reaches 4095
    assign w_pot_prod = {8'b0, i_pot_sample} * {12'b0, fsc_pkg::POT_GAIN};
    assign w_q0       = w_pot_prod[19:12];
    assign w_rem      = {1'b0, w_pot_prod[11:0]} + {5'b0, w_q0};

    always_comb begin
        o_job.ts        = i_timestamp_us;
        o_job.pot_speed = w_q0 + {7'b0, (w_rem >= fsc_pkg::POT_FULL_SCALE)};
        case (i_cmd)
            fsc_pkg::CMD_BUTTON:  o_job.op = fsc_pkg::OP_BUTTON;
            fsc_pkg::CMD_POT:     o_job.op = fsc_pkg::OP_POT;
            fsc_pkg::CMD_EDGE:    o_job.op = i_edge_level ? fsc_pkg::OP_RISE
                                                          : fsc_pkg::OP_FALL;
            default:              o_job.op = fsc_pkg::OP_REFRESH;
        endcase
    end

    assign o_stall = i_q_stat.full;
    assign o_push  = i_valid && !i_q_stat.full;

endmodule

`default_nettype wire

@@ rtl/core/fsc_queue.sv @@
// ----------------------------------------------------------------------------
// fsc_queue - job queue between front and back
// Small register FIFO; lets intake continue while the back end computes.
// ----------------------------------------------------------------------------
`default_nettype none

module fsc_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire fsc_pkg::t_job  i_job,
    input  wire logic           i_pop,
    output fsc_pkg::t_job       o_job,
    output fsc_pkg::t_q_stat    o_stat
);

    fsc_pkg::t_job                 r_mem [fsc_pkg::Q_DEPTH];
    logic [fsc_pkg::Q_PTR_W-1:0]   r_wr_ptr;
    logic [fsc_pkg::Q_PTR_W-1:0]   r_rd_ptr;
    logic [fsc_pkg::Q_CNT_W-1:0]   r_count;

    assign o_stat.full  = (r_count == fsc_pkg::Q_CNT_W'(fsc_pkg::Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_job        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("queue popped while empty");

endmodule

`default_nettype wire

@@ rtl/core/fsc_div.sv @@
// ----------------------------------------------------------------------------
// fsc_div - shared restoring divider
// One quotient bit per cycle; numerator is consumed MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module fsc_div (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire fsc_pkg::t_div_req i_req,
    output fsc_pkg::t_div_rsp   o_rsp
);

    logic [fsc_pkg::DIV_NUM_W-1:0] r_num;
    logic [fsc_pkg::DIV_DEN_W-1:0] r_den;
    logic [fsc_pkg::DIV_DEN_W-1:0] r_rem;
    logic [fsc_pkg::DIV_NUM_W-1:0] r_quot;
    logic [fsc_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;

    logic [fsc_pkg::DIV_DEN_W:0]   w_trial;
    logic [fsc_pkg::DIV_DEN_W:0]   w_diff;
    logic                          w_qbit;

    assign w_trial = {r_rem, r_num[fsc_pkg::DIV_NUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_qbit  = (w_trial >= {1'b0, r_den});

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num  <= i_req.num;
            r_den  <= i_req.den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[fsc_pkg::DIV_NUM_W-2:0], 1'b0};
            r_rem  <= w_qbit ? w_diff[fsc_pkg::DIV_DEN_W-1:0]
                             : w_trial[fsc_pkg::DIV_DEN_W-1:0];
            r_quot <= {r_quot[fsc_pkg::DIV_NUM_W-2:0], w_qbit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == fsc_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a run");

    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("divider busy with zero step count");

endmodule

`default_nettype wire

@@ rtl/core/fsc_back.sv @@
// ----------------------------------------------------------------------------
// fsc_back - job execution
// Holds the controller state, sequences angle and speed divides, and owns
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fsc_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_index,
    input  wire logic [11:0]           i_cfg_data,
    input  wire fsc_pkg::t_job         i_job,
    input  wire fsc_pkg::t_q_stat      i_q_stat,
    output logic                       o_pop,
    output fsc_pkg::t_div_req          o_div_req,
    input  wire fsc_pkg::t_div_rsp     i_div_rsp,
    input  wire logic                  i_stall,
    output logic                       o_valid,
    output logic [10:0]                o_pulse_width_us,
    output logic [1:0]                 o_direction,
    output logic [8:0]                 o_angle_deg,
    output logic signed [15:0]         o_rpm_tenths
);

    fsc_pkg::t_back_state r_state, n_state;

    // configuration
    logic [11:0] r_min_fb;
    logic [11:0] r_max_fb;

    // controller state
    logic        r_stopped;
    logic        r_clockwise;
    logic [7:0]  r_pot_speed;
    logic [10:0] r_drive;
    logic [31:0] r_rise_time;
    logic [31:0] r_last_fall;
    logic [8:0]  r_last_angle;
    logic        r_prev_valid;
    logic signed [15:0] r_speed;

    // working registers for a falling edge
    logic [31:0] r_ts;
    logic [31:0] r_high;
    logic [8:0]  r_angle_new;
    logic        r_neg;
    logic        r_do_speed;
    logic [fsc_pkg::DIV_NUM_W-1:0] r_num;
    logic [fsc_pkg::DIV_DEN_W-1:0] r_den;

    // result register
    logic        r_out_valid;
    logic [10:0] r_out_pulse;
    logic [1:0]  r_out_dir;
    logic [8:0]  r_out_angle;
    logic signed [15:0] r_out_rpm;

    logic        w_out_free;
    logic        w_out_load;
    logic        w_degenerate;
    logic        w_high_gt_lo;
    logic        w_high_ge_hi;
    logic        w_need_div;
    logic [8:0]  w_angle_fixed;
    logic [11:0] w_span_off;
    logic [11:0] w_span;
    logic [fsc_pkg::ANGLE_NUM_W-1:0] w_angle_prod;
    logic signed [9:0]  w_delta;
    logic [8:0]  w_mag;
    logic [31:0] w_speed_prod;
    logic [31:0] w_gap;
    logic        w_gap_ok;
    logic [fsc_pkg::DIV_NUM_W-1:0] w_quot;
    logic signed [15:0] w_speed_sat;

    assign w_out_free = !r_out_valid || !i_stall;

    // angle classification of the measured high time
    assign w_degenerate  = (r_max_fb <= r_min_fb);
    assign w_high_gt_lo  = (r_high > {20'b0, r_min_fb});
    assign w_high_ge_hi  = (r_high >= {20'b0, r_max_fb});
    assign w_need_div    = !w_degenerate && w_high_gt_lo && !w_high_ge_hi;
    assign w_angle_fixed = (w_degenerate ? w_high_gt_lo : w_high_ge_hi)
                           ? fsc_pkg::ANGLE_FULL : 9'd0;
    assign w_span_off    = r_high[11:0] - r_min_fb;
    assign w_span        = r_max_fb - r_min_fb;
    assign w_angle_prod  = {9'b0, w_span_off}
                           * fsc_pkg::ANGLE_NUM_W'(fsc_pkg::ANGLE_FULL);

    // speed numerator and denominator
    assign w_delta      = $signed({1'b0, r_last_angle}) - $signed({1'b0, r_angle_new});
    assign w_mag        = w_delta[9] ? 9'(-w_delta) : w_delta[8:0];
    assign w_speed_prod = {23'b0, w_mag} * fsc_pkg::SPEED_SCALE;
    assign w_gap        = r_ts - r_last_fall;
    assign w_gap_ok     = (w_gap != 32'd0);

    // saturate the quotient to the signed 16-bit result
    assign w_quot = i_div_rsp.quot;
    always_comb begin
        if (r_neg) begin
            w_speed_sat = (w_quot > fsc_pkg::DIV_NUM_W'(32768))
                          ? fsc_pkg::RPM_NEG_SAT : -$signed(w_quot[15:0]);
        end else begin
            w_speed_sat = (w_quot > fsc_pkg::DIV_NUM_W'(32767))
                          ? fsc_pkg::RPM_POS_SAT : $signed(w_quot[15:0]);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fsc_pkg::S_IDLE: begin
                if (!i_q_stat.empty) begin
                    n_state = (i_job.op == fsc_pkg::OP_FALL) ? fsc_pkg::S_ANGLE
                                                            : fsc_pkg::S_DONE;
                end
            end
            fsc_pkg::S_ANGLE: begin
                n_state = w_need_div ? fsc_pkg::S_ANGLE_DIV : fsc_pkg::S_SPEED_MUL;
            end
            fsc_pkg::S_ANGLE_DIV: begin
                if (i_div_rsp.done) begin
                    n_state = fsc_pkg::S_SPEED_MUL;
                end
            end
            fsc_pkg::S_SPEED_MUL: begin
                n_state = (r_prev_valid && w_gap_ok) ? fsc_pkg::S_SPEED_START
                                                     : fsc_pkg::S_DONE;
            end
            fsc_pkg::S_SPEED_START: n_state = fsc_pkg::S_SPEED_DIV;
            fsc_pkg::S_SPEED_DIV: begin
                if (i_div_rsp.done) begin
                    n_state = fsc_pkg::S_DONE;
                end
            end
            fsc_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = fsc_pkg::S_IDLE;
                end
            end
            default: n_state = fsc_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop      = 1'b0;
        w_out_load = 1'b0;
        o_div_req  = '0;
        case (r_state)
            fsc_pkg::S_IDLE: o_pop = !i_q_stat.empty;
            fsc_pkg::S_ANGLE: begin
                o_div_req.start = w_need_div;
                o_div_req.num   = {w_angle_prod, {fsc_pkg::ANGLE_PAD{1'b0}}};
                o_div_req.den   = {{(fsc_pkg::DIV_DEN_W - 12){1'b0}}, w_span};
                o_div_req.steps = fsc_pkg::ANGLE_STEPS;
            end
            fsc_pkg::S_SPEED_START: begin
                o_div_req.start = 1'b1;
                o_div_req.num   = r_num;
                o_div_req.den   = r_den;
                o_div_req.steps = fsc_pkg::SPEED_STEPS;
            end
            fsc_pkg::S_DONE: w_out_load = w_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fsc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_fb <= fsc_pkg::MIN_FEEDBACK_RST;
            r_max_fb <= fsc_pkg::MAX_FEEDBACK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fsc_pkg::CFG_MIN_FEEDBACK: r_min_fb <= i_cfg_data;
                default:                   r_max_fb <= i_cfg_data;
            endcase
        end
    end

    // controller state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stopped    <= 1'b1;
            r_clockwise  <= 1'b1;
            r_pot_speed  <= 8'd0;
            r_drive      <= fsc_pkg::PULSE_STOP;
            r_rise_time  <= 32'd0;
            r_last_fall  <= 32'd0;
            r_last_angle <= 9'd0;
            r_prev_valid <= 1'b0;
            r_speed      <= 16'sd0;
        end else begin
            if (o_pop) begin
                case (i_job.op)
                    fsc_pkg::OP_BUTTON: begin
                        if (!r_stopped) begin
                            r_stopped <= 1'b1;
                        end else begin
                            r_stopped   <= 1'b0;
                            r_clockwise <= !r_clockwise;
                        end
                    end
                    fsc_pkg::OP_POT:  r_pot_speed <= i_job.pot_speed;
                    fsc_pkg::OP_RISE: r_rise_time <= i_job.ts;
                    fsc_pkg::OP_REFRESH: begin
                        if (r_stopped) begin
                            r_drive <= fsc_pkg::PULSE_STOP;
                        end else if (r_clockwise) begin
                            r_drive <= fsc_pkg::PULSE_CW_BASE - {3'b0, r_pot_speed};
                        end else begin
                            r_drive <= fsc_pkg::PULSE_CCW_BASE + {3'b0, r_pot_speed};
                        end
                    end
                    default: ;
                endcase
            end
            if (r_state == fsc_pkg::S_SPEED_MUL) begin
                r_last_fall  <= r_ts;
                r_last_angle <= r_angle_new;
                r_prev_valid <= 1'b1;
            end
            if (r_state == fsc_pkg::S_SPEED_DIV && i_div_rsp.done) begin
                r_speed <= w_speed_sat;
            end
        end
    end

    // falling-edge working registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ts   <= i_job.ts;
            r_high <= i_job.ts - r_rise_time;
        end
        if (r_state == fsc_pkg::S_ANGLE) begin
            r_angle_new <= w_angle_fixed;
        end
        if (r_state == fsc_pkg::S_ANGLE_DIV && i_div_rsp.done) begin
            r_angle_new <= w_quot[8:0];
        end
        if (r_state == fsc_pkg::S_SPEED_MUL) begin
            r_neg      <= w_delta[9];
            r_do_speed <= r_prev_valid && w_gap_ok;
            r_num      <= w_speed_prod[fsc_pkg::DIV_NUM_W-1:0];
            r_den      <= {2'b0, w_gap} + {1'b0, w_gap, 1'b0};
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_pulse <= r_drive;
            r_out_dir   <= r_stopped ? fsc_pkg::DIR_STOP
                                     : (r_clockwise ? fsc_pkg::DIR_CW : fsc_pkg::DIR_CCW);
            r_out_angle <= r_last_angle;
            r_out_rpm   <= r_speed;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_pulse_width_us = r_out_pulse;
    assign o_direction      = r_out_dir;
    assign o_angle_deg      = r_out_angle;
    assign o_rpm_tenths     = r_out_rpm;

    a_speed_div_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fsc_pkg::S_SPEED_DIV) |-> r_do_speed)
        else $error("speed divide without a valid time gap");

    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_drive >= fsc_pkg::PULSE_MIN) && (r_drive <= fsc_pkg::PULSE_MAX))
        else $error("drive pulse out of range");

endmodule

`default_nettype wire

@@ test/feedback_servo_speed_controller_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// feedback_servo_speed_controller_test - self-checking bench for the servo
// speed controller.
// A queue of event beats feeds a driver that sends them in random bursts. A
// cycle-free model of the controller predicts one status beat per accepted
// event. A monitor pops and compares each status beat under a shifting stall
// pattern. The run steps through several feedback calibration spans,
// including the degenerate ones, and drains the controller before each
// register write.
// ----------------------------------------------------------------------------

module feedback_servo_speed_controller_test;

    typedef struct {
        logic [1:0]  cmd;
        logic [11:0] pot;
        logic        level;
        logic [31:0] ts;
    } t_servo_event;

    typedef struct {
        logic [10:0]        pulse;
        logic [1:0]         dir;
        logic [8:0]         angle;
        logic signed [15:0] rpm;
    } t_servo_status;

    // ---- DUT connections (all inputs known from time zero) ----
    logic               i_clk;
    logic               i_rst_n          = 1'b0;
    logic               i_cfg_we         = 1'b0;
    logic               i_cfg_index      = fsc_pkg::CFG_MIN_FEEDBACK;
    logic [11:0]        i_cfg_data       = '0;
    logic               i_valid          = 1'b0;
    logic               o_stall;
    logic [1:0]         i_cmd            = fsc_pkg::CMD_BUTTON;
    logic [11:0]        i_pot_sample     = '0;
    logic               i_edge_level     = 1'b0;
    logic [31:0]        i_timestamp_us   = '0;
    logic               o_valid;
    logic               i_stall          = 1'b0;
    logic [10:0]        o_pulse_width_us;
    logic [1:0]         o_direction;
    logic [8:0]         o_angle_deg;
    logic signed [15:0] o_rpm_tenths;

    feedback_servo_speed_controller uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_cmd            (i_cmd),
        .i_pot_sample     (i_pot_sample),
        .i_edge_level     (i_edge_level),
        .i_timestamp_us   (i_timestamp_us),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_pulse_width_us (o_pulse_width_us),
        .o_direction      (o_direction),
        .o_angle_deg      (o_angle_deg),
        .o_rpm_tenths     (o_rpm_tenths)
    );

    // ---- bookkeeping ----
    t_servo_event  pending_events[$];   // events waiting for the driver
    t_servo_status expected_status[$];  // predicted status beats, oldest first
    int unsigned   events_queued   = 0;
    int unsigned   events_accepted = 0;
    int unsigned   status_seen     = 0;
    int unsigned   mismatch_count  = 0;

    // ---- controller model state, same reset as the block ----
    logic [11:0]        span_min  = 12'd32;
    logic [11:0]        span_max  = 12'd1076;
    logic               m_stopped = 1'b1;
    logic               m_cw      = 1'b1;
    logic [11:0]        m_pot     = '0;
    logic [10:0]        m_pulse   = 11'd1500;
    logic [31:0]        m_rise    = '0;
    logic [31:0]        m_fall    = '0;
    logic [8:0]         m_angle   = '0;
    logic               m_had_fall = 1'b0;
    logic signed [15:0] m_rpm     = '0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop: far beyond the slowest legal run of ~1100 beats.
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // High time -> shaft angle under the current calibration span.
    // A span with max at or below min collapses to a step at min.
    function automatic logic [8:0] angle_from_high(input logic [31:0] high);
        if (span_max <= span_min)
            return (high > 32'(span_min)) ? 9'd360 : 9'd0;
        if (high <= 32'(span_min))
            return 9'd0;
        if (high >= 32'(span_max))
            return 9'd360;
        return 9'(((high - 32'(span_min)) * 32'd360) / 32'(span_max - span_min));
    endfunction

    // Angle change over elapsed microseconds -> tenths of rpm, truncated
    // toward zero, clamped to the signed 16-bit range.
    function automatic logic signed [15:0] rpm_from_delta(input int delta,
                                                          input logic [31:0] gap);
        longint unsigned mag;
        longint unsigned q;
        longint          s;
        mag = (delta < 0) ? longint'(-delta) : longint'(delta);
        q   = (mag * 64'd5000000) / ({32'd0, gap} * 64'd3);
        s   = (delta < 0) ? -longint'(q) : longint'(q);
        if (s > 32767)
            s = 32767;
        if (s < -32768)
            s = -32768;
        return 16'(s);
    endfunction

    // Apply one accepted event to the model and queue the status it yields.
    task automatic predict_status(input t_servo_event ev);
        t_servo_status st;
        logic [8:0]    ang;
        logic [31:0]   gap;
        int unsigned   trim;
        case (ev.cmd)
            fsc_pkg::CMD_BUTTON: begin
                // running -> stop; stop -> run the other way
                if (!m_stopped) begin
                    m_stopped = 1'b1;
                end else begin
                    m_stopped = 1'b0;
                    m_cw      = !m_cw;
                end
            end
            fsc_pkg::CMD_POT: begin
                m_pot = ev.pot;
            end
            fsc_pkg::CMD_EDGE: begin
                if (ev.level) begin
                    m_rise = ev.ts;
                end else begin
                    ang = angle_from_high(ev.ts - m_rise);   // wraps mod 2^32
                    if (m_had_fall) begin
                        gap = ev.ts - m_fall;
                        // zero gap keeps the previous speed
                        if (gap != 32'd0)
                            m_rpm = rpm_from_delta(int'(m_angle) - int'(ang), gap);
                    end
                    m_fall     = ev.ts;
                    m_angle    = ang;
                    m_had_fall = 1'b1;
                end
            end
            fsc_pkg::CMD_REFRESH: begin
                trim = (32'(m_pot) * 32'd200) / 32'd4095;
                if (m_stopped)
                    m_pulse = 11'd1500;
                else if (m_cw)
                    m_pulse = 11'(32'd1480 - trim);
                else
                    m_pulse = 11'(32'd1520 + trim);
            end
            default: ;
        endcase
        st.pulse = m_pulse;
        st.dir   = m_stopped ? fsc_pkg::DIR_STOP
                             : (m_cw ? fsc_pkg::DIR_CW : fsc_pkg::DIR_CCW);
        st.angle = m_angle;
        st.rpm   = m_rpm;
        expected_status.push_back(st);
    endtask

    task automatic queue_event(input logic [1:0] cmd, input logic [11:0] pot,
                               input logic level, input logic [31:0] ts);
        t_servo_event ev;
        ev.cmd   = cmd;
        ev.pot   = pot;
        ev.level = level;
        ev.ts    = ts;
        pending_events.push_back(ev);
        events_queued++;
    endtask

    // Block until every queued event is taken and every status beat is back.
    task automatic wait_drained();
        while (events_accepted != events_queued || expected_status.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Calibration writes, one per edge, only while the block is drained.
    task automatic write_span(input logic [11:0] lo, input logic [11:0] hi);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= fsc_pkg::CFG_MIN_FEEDBACK;
        i_cfg_data  <= lo;
        @(posedge i_clk);
        i_cfg_index <= fsc_pkg::CFG_MAX_FEEDBACK;
        i_cfg_data  <= hi;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        span_min = lo;
        span_max = hi;
    endtask

    // ------------------------------------------------------------------------
    // Event driver: bursts of random length separated by random pauses.
    // A stalled beat holds its payload; the model sees a beat on the edge
    // that takes it.
    // ------------------------------------------------------------------------
    t_servo_event on_wire;
    int unsigned  burst_left = 1;
    int unsigned  pause_left = 0;

    always @(posedge i_clk) begin : event_driver
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_status(on_wire);
                events_accepted++;
            end
            if (!i_valid || !o_stall) begin
                if (pause_left != 0) begin
                    pause_left--;
                    i_valid <= 1'b0;
                end else if (pending_events.size() != 0) begin
                    on_wire = pending_events.pop_front();
                    i_valid        <= 1'b1;
                    i_cmd          <= on_wire.cmd;
                    i_pot_sample   <= on_wire.pot;
                    i_edge_level   <= on_wire.level;
                    i_timestamp_us <= on_wire.ts;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        // a quarter of the bursts run back to back
                        pause_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Status monitor: compares each taken beat with the oldest prediction.
    // Stall pattern switches among free-running, light, heavy and periodic.
    // ------------------------------------------------------------------------
    int unsigned stall_mode = 0;
    int unsigned stall_hold = 0;
    int unsigned stall_tick = 0;

    always @(posedge i_clk) begin : status_monitor
        t_servo_status want;
        if (i_rst_n && o_valid && !i_stall) begin
            status_seen++;
            if (expected_status.size() == 0) begin
                report_mismatch($sformatf("status beat %0d with no event pending",
                                          status_seen));
            end else begin
                want = expected_status.pop_front();
                if (o_pulse_width_us !== want.pulse)
                    report_mismatch($sformatf("beat %0d pulse_width_us got %0d want %0d",
                                              status_seen, o_pulse_width_us, want.pulse));
                if (o_direction !== want.dir)
                    report_mismatch($sformatf("beat %0d direction got %0d want %0d",
                                              status_seen, o_direction, want.dir));
                if (o_angle_deg !== want.angle)
                    report_mismatch($sformatf("beat %0d angle_deg got %0d want %0d",
                                              status_seen, o_angle_deg, want.angle));
                if (o_rpm_tenths !== want.rpm)
                    report_mismatch($sformatf("beat %0d rpm_tenths got %0d want %0d",
                                              status_seen, o_rpm_tenths, want.rpm));
            end
        end
        if (stall_hold == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_hold = $urandom_range(20, 200);
        end else begin
            stall_hold--;
        end
        stall_tick++;
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 3) != 0);
            default: i_stall <= ((stall_tick % 7) < 3);
        endcase
    end

    // ------------------------------------------------------------------------
    // Stimulus: directed events, then random phases under several spans.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [31:0] now_us;
        int          made;
        int          pick;
        int          lo_b;
        int          hi_b;
        int          high;
        int          last_high;
        logic [31:0] step_us;

        i_rst_n <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // mode cycle and pulse extremes; stopped refresh ignores a full pot
        queue_event(fsc_pkg::CMD_POT,     12'hFFF, 1'b1, 32'hFFFF_FFFF);
        queue_event(fsc_pkg::CMD_REFRESH, 12'h000, 1'b0, 32'h0000_0000);
        queue_event(fsc_pkg::CMD_BUTTON,  12'hAAA, 1'b1, 32'h5555_5555);   // run ccw
        queue_event(fsc_pkg::CMD_REFRESH, 12'h555, 1'b0, 32'hAAAA_AAAA);   // 1720
        queue_event(fsc_pkg::CMD_BUTTON,  12'h000, 1'b0, 32'h0000_0000);   // stop
        queue_event(fsc_pkg::CMD_REFRESH, 12'hFFF, 1'b1, 32'hFFFF_FFFF);
        queue_event(fsc_pkg::CMD_BUTTON,  12'h123, 1'b0, 32'h1234_5678);   // run cw
        queue_event(fsc_pkg::CMD_REFRESH, 12'h000, 1'b1, 32'h8765_4321);   // 1280
        queue_event(fsc_pkg::CMD_POT,     12'h000, 1'b0, 32'h0000_0001);
        queue_event(fsc_pkg::CMD_REFRESH, 12'hFFF, 1'b0, 32'h0000_0000);   // 1480
        queue_event(fsc_pkg::CMD_POT,     12'h800, 1'b1, 32'h0);
        queue_event(fsc_pkg::CMD_REFRESH, 12'h0,   1'b0, 32'h0);
        // first fall only stores; high time below min gives angle 0
        queue_event(fsc_pkg::CMD_EDGE, 12'h0, 1'b1, 32'd1000);
        queue_event(fsc_pkg::CMD_EDGE, 12'h0, 1'b0, 32'd1020);
        // above max gives 360; big negative change saturates low
        queue_event(fsc_pkg::CMD_EDGE, 12'h0, 1'b1, 32'd2000);
        queue_event(fsc_pkg::CMD_EDGE, 12'h0, 1'b0, 32'd4000);
        // rise before the timer wraps, fall after it
        queue_event(fsc_pkg::CMD_EDGE, 12'h0, 1'b1, 32'hFFFF_FF00);
        queue_event(fsc_pkg::CMD_EDGE, 12'h0, 1'b0, 32'h0000_0200);
        // same fall time again: zero gap keeps the speed
        queue_event(fsc_pkg::CMD_EDGE, 12'h0, 1'b0, 32'h0000_0200);
        // high time exactly min, short gap: saturates high
        queue_event(fsc_pkg::CMD_EDGE, 12'h0, 1'b1, 32'h0000_0300);
        queue_event(fsc_pkg::CMD_EDGE, 12'h0, 1'b0, 32'h0000_0320);
        // mid angle over a long gap: moderate negative speed
        queue_event(fsc_pkg::CMD_EDGE, 12'h0, 1'b1, 32'd100000);
        queue_event(fsc_pkg::CMD_EDGE, 12'h0, 1'b0, 32'd100554);
        // high time exactly max
        queue_event(fsc_pkg::CMD_EDGE, 12'h0, 1'b1, 32'd200000);
        queue_event(fsc_pkg::CMD_EDGE, 12'h0, 1'b0, 32'd201076);

        now_us    = $urandom;
        last_high = 500;
        for (int phase = 0; phase < 7; phase++) begin
            // drain completely before touching the span (sender holds off)
            wait_drained();
            case (phase)
                0: ;                                  // reset span
                1: write_span(12'd0,    12'd4095);
                2: write_span(12'd4095, 12'd1);       // inverted span
                3: write_span(12'd600,  12'd600);     // empty span
                4: write_span(12'd0,    12'd1);
                5: write_span(12'($urandom_range(0, 2000)),
                              12'($urandom_range(2001, 4095)));
                default: write_span(12'd32, 12'd1076);
            endcase

            made = 0;
            while (made < 147) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    // one well-formed feedback pulse: rise, then fall
                    lo_b = (span_min < span_max) ? int'(span_min) : int'(span_max);
                    hi_b = (span_min < span_max) ? int'(span_max) : int'(span_min);
                    if ($urandom_range(0, 1) == 0)
                        high = last_high + $urandom_range(0, 16) - 8;   // slow drift
                    else
                        high = $urandom_range((lo_b > 24) ? lo_b - 24 : 0, hi_b + 24);
                    if ($urandom_range(0, 19) == 0)
                        high = $urandom_range(0, 8000);
                    if (high < 0)
                        high = 0;
                    last_high = high;
                    queue_event(fsc_pkg::CMD_EDGE, 12'($urandom), 1'b1, now_us);
                    queue_event(fsc_pkg::CMD_EDGE, 12'($urandom), 1'b0,
                                now_us + 32'(high));
                    made += 2;
                    if ($urandom_range(0, 14) == 0) begin
                        queue_event(fsc_pkg::CMD_EDGE, 12'($urandom), 1'b0,
                                    now_us + 32'(high));
                        made++;
                    end
                    case ($urandom_range(0, 9))
                        0:       step_us = $urandom;                 // long jump, wraps
                        1:       step_us = $urandom_range(0, 50);
                        default: step_us = $urandom_range(200, 20000);
                    endcase
                    now_us = now_us + 32'(high) + step_us;
                end else if (pick < 58) begin
                    queue_event(fsc_pkg::CMD_BUTTON, 12'($urandom), 1'($urandom),
                                $urandom);
                    made++;
                end else if (pick < 70) begin
                    case ($urandom_range(0, 9))
                        0:       queue_event(fsc_pkg::CMD_POT, 12'h000, 1'($urandom),
                                             $urandom);
                        1:       queue_event(fsc_pkg::CMD_POT, 12'hFFF, 1'($urandom),
                                             $urandom);
                        default: queue_event(fsc_pkg::CMD_POT, 12'($urandom),
                                             1'($urandom), $urandom);
                    endcase
                    made++;
                end else if (pick < 88) begin
                    queue_event(fsc_pkg::CMD_REFRESH, 12'($urandom), 1'($urandom),
                                $urandom);
                    made++;
                end else begin
                    // noise: stray edges at arbitrary times, or any event at all
                    if ($urandom_range(0, 1) == 0)
                        queue_event(fsc_pkg::CMD_EDGE, 12'($urandom), 1'($urandom),
                                    $urandom);
                    else
                        queue_event(2'($urandom), 12'($urandom), 1'($urandom), $urandom);
                    made++;
                end
            end
        end

        wait_drained();
        // longest job is a falling edge with two divides
        repeat (100) @(posedge i_clk);
        if (expected_status.size() != 0)
            report_mismatch($sformatf("%0d status beats never arrived",
                                      expected_status.size()));
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
